### rtl/plc_pkg.sv
// plc_pkg: shared types, codes and constants of the pump level controller
// used by pump_level_controller; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

    // stream widths, padded to whole bytes
    localparam int InDataW  = 120;
    localparam int OutDataW = 24;

    // configuration port
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 22;

    localparam logic [CfgAddrW-1:0] CFG_PUMP_MODE   = 3'd0;
    localparam logic [CfgAddrW-1:0] CFG_START_LEVEL = 3'd1;
    localparam logic [CfgAddrW-1:0] CFG_STOP_LEVEL  = 3'd2;
    localparam logic [CfgAddrW-1:0] CFG_BYPASS      = 3'd3;
    localparam logic [CfgAddrW-1:0] CFG_STALE_MS    = 3'd4;
    localparam logic [CfgAddrW-1:0] CFG_MIN_OFF_MS  = 3'd5;

    // operating modes; the unused code runs as auto
    localparam logic [1:0] PMODE_AUTO      = 2'd0;
    localparam logic [1:0] PMODE_MANUAL    = 2'd1;
    localparam logic [1:0] PMODE_COUNTDOWN = 2'd2;

    // safety verdicts; the unused codes mean no stop
    localparam logic [1:0] SAFE_DRY_RUN  = 2'd1;
    localparam logic [1:0] SAFE_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        RM_MANUAL_COOL = 3'd0,
        RM_AUTO_COOL   = 3'd1,
        RM_COUNTDOWN   = 3'd2,
        RM_MANUAL_ON   = 3'd3,
        RM_MANUAL_OFF  = 3'd4,
        RM_AUTO        = 3'd5,
        RM_AUTO_STBY   = 3'd6
    } t_run_mode;

    typedef enum logic [2:0] {
        FLT_NONE      = 3'd0,
        FLT_ESTOP     = 3'd1,
        FLT_DRY_RUN   = 3'd2,
        FLT_OVERFLOW  = 3'd3,
        FLT_COMM_LOSS = 3'd4,
        FLT_STALE     = 3'd5,
        FLT_SENSOR    = 3'd6
    } t_fault;

    // reset values of the configuration registers
    localparam logic [6:0]  START_LEVEL_RST = 7'd30;
    localparam logic [6:0]  STOP_LEVEL_RST  = 7'd90;
    localparam logic [19:0] STALE_MS_RST    = 20'd10000;
    localparam logic [21:0] MIN_OFF_MS_RST  = 22'd30000;

    // ms to seconds: x / 1000 = (x >> 3) / 125, done as multiply by
    // ceil(2^26 / 125) and shift; exact for the 19-bit shifted value
    localparam int            RecipShift = 26;
    localparam logic [19:0]   Recip125   = 20'd536871;
    localparam logic [11:0]   CoolSecMax = 12'd4095;

    // input item, first field in the lowest bits
    typedef struct packed {
        logic [6:0]        pad;
        logic [31:0]       countdown_end_ms;
        logic              countdown_start;
        logic              manual_request;
        logic              sleeping;
        logic              estop_latched;
        logic              level_sensor_fault;
        logic              sensor_stable;
        logic              near_runtime_limit;
        logic [1:0]        safety_stop;
        logic [31:0]       level_stamp_ms;
        logic signed [7:0] level_pct;
        logic [31:0]       now_ms;
    } t_in_item;

    // result item, first field in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic        countdown_running;
        logic        runtime_warning;
        logic [11:0] cooldown_sec;
        t_fault      fault_code;
        t_run_mode   run_mode;
        logic        pump_on;
    } t_out_item;

endpackage

`default_nettype wire

### rtl/pump_level_controller.sv
// pump_level_controller: one pump decision per control tick, three-stage pipeline
// depends on plc_pkg (types, codes, reset values, reciprocal constants)
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input stream (i_s_axis_*): one control tick per transfer, fields packed in
//   tdata. Output stream (o_m_axis_*): one result per tick, in tick order.
//   Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_addr at the
//   clock edge; write only while no tick is in flight.
// Timing
//   A tick passes an input register, the decision stage (which updates the
//   controller state) and a result stage where the cooldown is turned into
//   seconds by one constant multiply. One tick is accepted every cycle unless
//   the output stalls; the state feedback closes inside the decision stage,
//   so back-to-back ticks see each other's effect.
// Stall
//   Each stage fills a bubble ahead of it, so input stays ready while the
//   output waits until all three stages hold a tick; a stalled result holds.
// Reset
//   i_rst_n low (synchronous) empties the pipeline, puts the pump off, clears
//   fault, countdown and warning, shows auto standby and loads the register
//   defaults.

module pump_level_controller (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tick: now_ms, level_pct, level_stamp_ms, safety_stop, near_runtime_limit,
    // sensor_stable, level_sensor_fault, estop_latched, sleeping,
    // manual_request, countdown_start, countdown_end_ms, zero pad
    input  wire logic [plc_pkg::InDataW-1:0]   i_s_axis_tdata,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // result: pump_on, run_mode, fault_code, cooldown_sec, runtime_warning,
    // countdown_running, zero pad
    output logic [plc_pkg::OutDataW-1:0]       o_m_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // configuration write
    input  wire logic                          i_cfg_we,
    input  wire logic [plc_pkg::CfgAddrW-1:0]  i_cfg_addr,
    input  wire logic [plc_pkg::CfgDataW-1:0]  i_cfg_wdata
);
    import plc_pkg::*;

    // configuration registers
    logic [1:0]  r_pump_mode;
    logic [6:0]  r_start_level;
    logic [6:0]  r_stop_level;
    logic        r_bypass;
    logic [19:0] r_stale_ms;
    logic [21:0] r_min_off_ms;

    // controller state
    logic        r_running, n_running;
    logic        r_off_valid, n_off_valid;
    logic [31:0] r_off_since, n_off_since;
    logic        r_cd_active, n_cd_active;
    logic [31:0] r_cd_deadline, n_cd_deadline;
    t_fault      r_last_fault, n_last_fault;
    t_run_mode   r_mode_shown, n_mode_shown;
    logic        r_warn, n_warn;
    logic [11:0] r_cooldown;

    // pipeline registers
    logic        r_a_vld, r_b_vld, r_c_vld;
    t_in_item    r_a_item;
    logic        r_b_cool_upd, n_cool_upd;
    logic [21:0] r_b_remain, n_remain;
    logic        r_b_pump_on;
    t_run_mode   r_b_mode;
    t_fault      r_b_fault;
    logic        r_b_warn;
    logic        r_b_cd_run;
    logic        r_c_pump_on;
    t_run_mode   r_c_mode;
    t_fault      r_c_fault;
    logic        r_c_warn;
    logic        r_c_cd_run;

    logic        s_a_ld, s_b_ld, s_c_ld;

    // decision helpers
    logic        is_manual, is_cdown;
    logic [31:0] cd_gap, off_gap, stamp_gap;
    logic        fresh, allow, cool, lvl_ge_stop, lvl_le_start, intent;
    logic        do_stop, do_start, cd_clear;
    logic [31:0] cd_dl_arm;
    logic        cd_act_arm;
    logic        cd_expire, cd_live;
    t_fault      link_fault;
    t_out_item   out_item;
    logic [38:0] sec_prod;
    logic [12:0] sec_raw;
    logic [11:0] sec_sat;

    // pipeline flow: each stage loads when the one ahead moves or is empty
    assign s_c_ld          = r_b_vld && (!r_c_vld || i_m_axis_tready);
    assign s_b_ld          = r_a_vld && (!r_b_vld || s_c_ld);
    assign o_s_axis_tready = !r_a_vld || s_b_ld;
    assign s_a_ld          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= s_a_ld || (r_a_vld && !s_b_ld);
            r_b_vld <= s_b_ld || (r_b_vld && !s_c_ld);
            r_c_vld <= s_c_ld || (r_c_vld && !i_m_axis_tready);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump_mode   <= PMODE_AUTO;
            r_start_level <= START_LEVEL_RST;
            r_stop_level  <= STOP_LEVEL_RST;
            r_bypass      <= 1'b0;
            r_stale_ms    <= STALE_MS_RST;
            r_min_off_ms  <= MIN_OFF_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PUMP_MODE:   r_pump_mode   <= i_cfg_wdata[1:0];
                CFG_START_LEVEL: r_start_level <= i_cfg_wdata[6:0];
                CFG_STOP_LEVEL:  r_stop_level  <= i_cfg_wdata[6:0];
                CFG_BYPASS:      r_bypass      <= i_cfg_wdata[0];
                CFG_STALE_MS:    r_stale_ms    <= i_cfg_wdata[19:0];
                CFG_MIN_OFF_MS:  r_min_off_ms  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (s_a_ld) begin
            r_a_item <= t_in_item'(i_s_axis_tdata);
        end
    end

    // arm and expire the countdown ahead of the decision
    assign is_manual = r_pump_mode == PMODE_MANUAL;
    assign is_cdown  = r_pump_mode == PMODE_COUNTDOWN;
    assign cd_act_arm = r_cd_active || (r_a_item.countdown_start && is_cdown);
    assign cd_dl_arm  = (r_a_item.countdown_start && is_cdown) ?
                        r_a_item.countdown_end_ms : r_cd_deadline;
    assign cd_gap     = r_a_item.now_ms - cd_dl_arm;
    assign cd_expire  = cd_act_arm && is_cdown && !cd_gap[31];
    assign cd_live    = cd_act_arm && !cd_expire;

    // wrap-safe time tests
    assign stamp_gap = r_a_item.now_ms - r_a_item.level_stamp_ms;
    assign fresh     = (r_a_item.level_stamp_ms != 32'd0) && (stamp_gap[31:20] == 12'd0)
                       && (stamp_gap[19:0] <= r_stale_ms);
    assign allow     = r_a_item.sensor_stable && fresh && !r_a_item.level_sensor_fault
                       && !r_bypass;
    assign off_gap   = r_a_item.now_ms - r_off_since;
    assign cool      = !r_running && r_off_valid && (off_gap[31:22] == 10'd0)
                       && (off_gap[21:0] < r_min_off_ms);
    assign lvl_ge_stop  = r_a_item.level_pct[6:0] >= r_stop_level;
    assign lvl_le_start = r_a_item.level_pct[6:0] <= r_start_level;
    assign intent       = is_manual ? r_a_item.manual_request : cd_live;
    assign link_fault   = (!r_a_item.sensor_stable || !fresh) ? FLT_COMM_LOSS : FLT_STALE;

    // decision, given a sample: priority order estop, safety stop, then mode logic
    always_comb begin
        n_cd_active   = cd_act_arm;
        n_cd_deadline = cd_dl_arm;
        if (cd_expire) begin
            n_cd_active   = 1'b0;
            n_cd_deadline = 32'd0;
        end
        n_last_fault = r_last_fault;
        n_mode_shown = r_mode_shown;
        n_warn       = r_warn;
        n_cool_upd   = 1'b0;
        n_remain     = 22'd0;
        do_stop      = 1'b0;
        do_start     = 1'b0;
        cd_clear     = 1'b0;
        if (!r_a_item.level_pct[7]) begin
            if (r_a_item.estop_latched) begin
                n_last_fault = FLT_ESTOP;
                do_stop      = 1'b1;
            end else begin
                n_warn = r_running && is_manual && r_a_item.near_runtime_limit;
                if (r_a_item.safety_stop == SAFE_DRY_RUN ||
                    r_a_item.safety_stop == SAFE_OVERFLOW) begin
                    n_last_fault = (r_a_item.safety_stop == SAFE_DRY_RUN) ?
                                   FLT_DRY_RUN : FLT_OVERFLOW;
                    do_stop      = 1'b1;
                    cd_clear     = 1'b1;
                end else begin
                    // cooldown and shown mode follow the state before this tick
                    n_cool_upd = 1'b1;
                    if (cool) begin
                        n_remain     = r_min_off_ms - off_gap[21:0];
                        n_mode_shown = is_manual ? RM_MANUAL_COOL :
                                       (is_cdown ? RM_COUNTDOWN : RM_AUTO_COOL);
                    end else if (is_manual) begin
                        n_mode_shown = (r_running && r_a_item.manual_request) ?
                                       RM_MANUAL_ON : RM_MANUAL_OFF;
                    end else if (is_cdown) begin
                        n_mode_shown = RM_COUNTDOWN;
                    end else begin
                        n_mode_shown = r_running ? RM_AUTO : RM_AUTO_STBY;
                    end
                    // manual and countdown run on intent
                    if (is_manual || is_cdown) begin
                        priority if (!intent) begin
                            do_stop = 1'b1;
                        end else if (!r_bypass && !allow) begin
                            if (r_running || is_cdown) begin
                                n_last_fault = link_fault;
                            end
                            do_stop  = 1'b1;
                            cd_clear = is_cdown;
                        end else if (!r_bypass && lvl_ge_stop) begin
                            do_stop  = 1'b1;
                            cd_clear = is_cdown;
                        end else begin
                            do_start = !cool;
                        end
                    // auto: hysteresis with minimum off time
                    end else begin
                        priority if (r_a_item.sleeping) begin
                            do_stop = r_running && lvl_ge_stop;
                        end else if (r_bypass) begin
                            do_stop = 1'b0;
                        end else if (!allow) begin
                            if (r_running) begin
                                n_last_fault = link_fault;
                                do_stop      = 1'b1;
                            end
                        end else if (!r_running && lvl_le_start) begin
                            do_start = !cool;
                        end else begin
                            do_stop = r_running && lvl_ge_stop;
                        end
                    end
                end
            end
        end
        if (cd_clear) begin
            n_cd_active   = 1'b0;
            n_cd_deadline = 32'd0;
        end
        // pump drive and off-time record
        n_running   = r_running;
        n_off_valid = r_off_valid;
        n_off_since = r_off_since;
        if (do_stop && r_running) begin
            n_running   = 1'b0;
            n_off_valid = 1'b1;
            n_off_since = r_a_item.now_ms;
        end else if (do_start) begin
            n_running = 1'b1;
        end
    end

    // state registers advance with the tick entering the decision stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_off_valid   <= 1'b0;
            r_off_since   <= 32'd0;
            r_cd_active   <= 1'b0;
            r_cd_deadline <= 32'd0;
            r_last_fault  <= FLT_NONE;
            r_mode_shown  <= RM_AUTO_STBY;
            r_warn        <= 1'b0;
        end else if (s_b_ld) begin
            r_running     <= n_running;
            r_off_valid   <= n_off_valid;
            r_off_since   <= n_off_since;
            r_cd_active   <= n_cd_active;
            r_cd_deadline <= n_cd_deadline;
            r_last_fault  <= n_last_fault;
            r_mode_shown  <= n_mode_shown;
            r_warn        <= n_warn;
        end
    end

    // decision stage payload
    always_ff @(posedge i_clk) begin
        if (s_b_ld) begin
            r_b_cool_upd <= n_cool_upd;
            r_b_remain   <= n_remain;
            r_b_pump_on  <= n_running;
            r_b_mode     <= n_mode_shown;
            r_b_fault    <= n_last_fault;
            r_b_warn     <= n_warn;
            r_b_cd_run   <= n_cd_active;
        end
    end

    // remaining ms to whole seconds, saturated to 12 bits
    assign sec_prod = {20'd0, r_b_remain[21:3]} * {19'd0, Recip125};
    assign sec_raw  = sec_prod[38:RecipShift];
    assign sec_sat  = sec_raw[12] ? CoolSecMax : sec_raw[11:0];

    // result register; cooldown holds on the early-exit paths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cooldown <= 12'd0;
        end else if (s_c_ld && r_b_cool_upd) begin
            r_cooldown <= sec_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_c_ld) begin
            r_c_pump_on <= r_b_pump_on;
            r_c_mode    <= r_b_mode;
            r_c_fault   <= r_b_fault;
            r_c_warn    <= r_b_warn;
            r_c_cd_run  <= r_b_cd_run;
        end
    end

    always_comb begin
        out_item                   = '0;
        out_item.pump_on           = r_c_pump_on;
        out_item.run_mode          = r_c_mode;
        out_item.fault_code        = r_c_fault;
        out_item.cooldown_sec      = r_cooldown;
        out_item.runtime_warning   = r_c_warn;
        out_item.countdown_running = r_c_cd_run;
    end

    assign o_m_axis_tdata  = OutDataW'(out_item);
    assign o_m_axis_tvalid = r_c_vld;

    // a sensor fault is reported as a link fault, never with its own code
    a_no_sensor_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_item.fault_code != FLT_SENSOR))
        else $error("sensor fault code produced");

    // an emergency stop on a valid sample leaves the pump off
    a_estop_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_b_ld && !r_a_item.level_pct[7] && r_a_item.estop_latched) |=> !r_running)
        else $error("pump running after emergency stop");

    // a pending cooldown means the pump is off
    a_cool_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && out_item.cooldown_sec != 12'd0) |-> !out_item.pump_on)
        else $error("pump on during cooldown");

    // state changes only when a tick enters the decision stage
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_b_ld |=> ($stable(r_running) && $stable(r_last_fault)))
        else $error("state changed without a tick");

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for pump_level_controller; directed and random control
// ticks with random gaps and stalls, each status checked against an in-bench pump model
// depends on plc_pkg and pump_level_controller

module tb_top;
    import plc_pkg::*;

    localparam int RstCycles   = 11;
    localparam int CycleLimit  = 200000;
    localparam int PhaseTicks  = 155;
    localparam int IdlePct     = 33;
    localparam int HoldCycles  = 80;
    localparam int HoldAfter   = 300;
    localparam int DrainCycles = 8;
    localparam logic [31:0] MsPerSec    = 32'd1000;
    localparam logic [31:0] CoolCeiling = 32'd4095;
    // pump mode code with no name of its own, runs as auto
    localparam logic [1:0] PMODE_SPARE = 2'd3;
    // safety code with no name of its own, means no stop
    localparam logic [1:0] SAFE_SPARE  = 2'd3;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic [InDataW-1:0]  tick_tdata   = '0;
    logic                tick_tvalid  = 1'b0;
    logic                tick_tready;
    logic [OutDataW-1:0] stat_tdata;
    logic                stat_tvalid;
    logic                stat_tready  = 1'b0;
    logic                cfg_we       = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr     = '0;
    logic [CfgDataW-1:0] cfg_wdata    = '0;

    pump_level_controller u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (tick_tdata),
        .i_s_axis_tvalid (tick_tvalid),
        .o_s_axis_tready (tick_tready),
        .o_m_axis_tdata  (stat_tdata),
        .o_m_axis_tvalid (stat_tvalid),
        .i_m_axis_tready (stat_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // model copy of the configuration registers
    logic [1:0]  pm_mode;
    logic [6:0]  pm_start;
    logic [6:0]  pm_stop;
    logic        pm_bypass;
    logic [19:0] pm_stale;
    logic [21:0] pm_min_off;

    // model copy of the controller state
    logic        ps_running;
    logic        ps_off_valid;
    logic [31:0] ps_off_since;
    logic        ps_cd_active;
    logic [31:0] ps_cd_deadline;
    t_fault      ps_fault;
    t_run_mode   ps_mode_shown;
    logic [11:0] ps_cool_sec;
    logic        ps_warn;

    t_in_item  pending_ticks[$];
    t_out_item due_status[$];

    int n_ticks    = 0;
    int n_offered  = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_pump_on  = 0;
    int n_settings = 1;
    int n_cycles   = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    // stimulus state: running clock, tank level and the user's manual wish
    logic [31:0] sim_now;
    int          sim_level;
    logic        sim_mreq;

    // window with no idling on either side
    logic calm;
    assign calm = (n_ticks >= 700) && (n_ticks < 950);

    // stop the pump, remembering when it went off
    function automatic void pump_halt(input logic [31:0] now);
        if (ps_running) begin
            ps_running   = 1'b0;
            ps_off_since = now;
            ps_off_valid = 1'b1;
        end
    endfunction

    function automatic void countdown_drop();
        ps_cd_active   = 1'b0;
        ps_cd_deadline = '0;
    endfunction

    // pump off and minimum off time not yet over, modulo 2^32
    function automatic logic in_cooldown(input logic [31:0] now);
        logic [31:0] since;
        since = now - ps_off_since;
        return !ps_running && ps_off_valid && (since < {10'd0, pm_min_off});
    endfunction

    // one control tick applied to the model state
    function automatic void pump_tick(input t_in_item it);
        logic [31:0] now;
        logic [31:0] age;
        logic [31:0] span;
        logic [31:0] remain;
        logic        manual;
        logic        cdown;
        logic        fresh;
        logic        allow;
        logic        lost;
        logic        intent;
        int          lvl;
        int          start_lv;
        int          stop_lv;
        now      = it.now_ms;
        lvl      = int'(it.level_pct);
        start_lv = int'(pm_start);
        stop_lv  = int'(pm_stop);
        manual   = (pm_mode == PMODE_MANUAL);
        cdown    = (pm_mode == PMODE_COUNTDOWN);

        // countdown arm, then expiry once the deadline is reached
        if (it.countdown_start && cdown) begin
            ps_cd_active   = 1'b1;
            ps_cd_deadline = it.countdown_end_ms;
        end
        span = now - ps_cd_deadline;
        if (ps_cd_active && cdown && !span[31]) countdown_drop();

        // no level sample yet: state stands
        if (lvl < 0) return;

        if (it.estop_latched) begin
            ps_fault = FLT_ESTOP;
            pump_halt(now);
            return;
        end
        ps_warn = ps_running && manual && it.near_runtime_limit;

        if (it.safety_stop == SAFE_DRY_RUN || it.safety_stop == SAFE_OVERFLOW) begin
            if (it.safety_stop == SAFE_DRY_RUN) ps_fault = FLT_DRY_RUN;
            else ps_fault = FLT_OVERFLOW;
            pump_halt(now);
            countdown_drop();
            return;
        end

        // sensor freshness gate
        age   = now - it.level_stamp_ms;
        fresh = (it.level_stamp_ms != '0) && (age <= {12'd0, pm_stale});
        allow = it.sensor_stable && fresh && !it.level_sensor_fault && !pm_bypass;
        lost  = !it.sensor_stable || !fresh;

        // shown mode and cooldown seconds
        if (in_cooldown(now)) begin
            span   = now - ps_off_since;
            remain = ({10'd0, pm_min_off} - span) / MsPerSec;
            ps_cool_sec = (remain > CoolCeiling) ? CoolCeiling[11:0] : remain[11:0];
            if (manual) ps_mode_shown = RM_MANUAL_COOL;
            else if (cdown) ps_mode_shown = RM_COUNTDOWN;
            else ps_mode_shown = RM_AUTO_COOL;
        end else begin
            ps_cool_sec = '0;
            if (manual) begin
                if (ps_running && it.manual_request) ps_mode_shown = RM_MANUAL_ON;
                else ps_mode_shown = RM_MANUAL_OFF;
            end else if (cdown) begin
                ps_mode_shown = RM_COUNTDOWN;
            end else if (ps_running) begin
                ps_mode_shown = RM_AUTO;
            end else begin
                ps_mode_shown = RM_AUTO_STBY;
            end
        end

        // manual and countdown run on intent
        if (manual || cdown) begin
            intent = manual ? it.manual_request : ps_cd_active;
            if (!intent) begin
                pump_halt(now);
                return;
            end
            if (!pm_bypass && !allow) begin
                if (ps_running || cdown) begin
                    if (lost) ps_fault = FLT_COMM_LOSS;
                    else ps_fault = FLT_STALE;
                end
                pump_halt(now);
                if (cdown) countdown_drop();
                return;
            end
            if (!pm_bypass && lvl >= stop_lv) begin
                pump_halt(now);
                if (cdown) countdown_drop();
                return;
            end
            if (!in_cooldown(now)) ps_running = 1'b1;
            return;
        end

        // auto: sleep only stops, then hysteresis behind the gate
        if (it.sleeping) begin
            if (ps_running && lvl >= stop_lv) pump_halt(now);
            return;
        end
        if (pm_bypass) return;
        if (!allow) begin
            if (ps_running) begin
                if (lost) ps_fault = FLT_COMM_LOSS;
                else ps_fault = FLT_STALE;
                pump_halt(now);
            end
            return;
        end
        if (!ps_running && lvl <= start_lv) begin
            if (!in_cooldown(now)) ps_running = 1'b1;
        end else if (ps_running && lvl >= stop_lv) begin
            pump_halt(now);
        end
    endfunction

    // tick with a fresh sample and a stable link, nothing else asserted
    function automatic t_in_item healthy(input logic [31:0] now, input int lvl);
        t_in_item it;
        it                = '0;
        it.now_ms         = now;
        it.level_pct      = lvl[7:0];
        it.level_stamp_ms = now;
        it.sensor_stable  = 1'b1;
        return it;
    endfunction

    // random tick: mostly a plausible plant, some pure noise
    function automatic t_in_item field_tick();
        t_in_item it;
        int       r;
        int       step;
        it = '0;
        if ($urandom_range(99) < 8) begin
            r = $urandom_range(101);
            r = r - 1;
            it.now_ms             = $urandom;
            it.level_pct          = r[7:0];
            it.level_stamp_ms     = $urandom;
            it.safety_stop        = 2'($urandom_range(3));
            it.near_runtime_limit = 1'($urandom_range(1));
            it.sensor_stable      = 1'($urandom_range(1));
            it.level_sensor_fault = 1'($urandom_range(1));
            it.estop_latched      = 1'($urandom_range(1));
            it.sleeping           = 1'($urandom_range(1));
            it.manual_request     = 1'($urandom_range(1));
            it.countdown_start    = 1'($urandom_range(1));
            it.countdown_end_ms   = $urandom;
            return it;
        end

        // time moves on, the level drifts
        r = $urandom_range(199);
        if (r == 0) sim_now = $urandom;
        else if (r < 20) sim_now = sim_now + $urandom_range(60000);
        else sim_now = sim_now + $urandom_range(1, 2500);
        if ($urandom_range(19) == 0) begin
            sim_level = $urandom_range(100);
        end else begin
            step      = $urandom_range(16);
            sim_level = sim_level + step - 8;
        end
        if (sim_level < 0) sim_level = 0;
        if (sim_level > 100) sim_level = 100;
        if ($urandom_range(99) < 15) sim_mreq = ~sim_mreq;

        it.now_ms    = sim_now;
        it.level_pct = ($urandom_range(99) < 4) ? 8'hFF : sim_level[7:0];
        r = $urandom_range(99);
        if (r < 4) it.level_stamp_ms = '0;
        else if (r < 8) it.level_stamp_ms = $urandom;
        else if (r < 16) it.level_stamp_ms = sim_now - $urandom_range(700000);
        else if (r < 46) it.level_stamp_ms = sim_now;
        else it.level_stamp_ms = sim_now - $urandom_range(8000);

        r = $urandom_range(99);
        if (r < 2) it.safety_stop = SAFE_DRY_RUN;
        else if (r < 4) it.safety_stop = SAFE_OVERFLOW;
        else if (r < 6) it.safety_stop = SAFE_SPARE;
        it.near_runtime_limit = ($urandom_range(99) < 30);
        it.sensor_stable      = ($urandom_range(99) < 96);
        it.level_sensor_fault = ($urandom_range(99) < 3);
        it.estop_latched      = ($urandom_range(99) < 2);
        it.sleeping           = ($urandom_range(99) < 10);
        it.manual_request     = sim_mreq;
        it.countdown_start    = ($urandom_range(99) < 10);
        r = $urandom_range(99);
        if (r < 15) it.countdown_end_ms = $urandom;
        else if (r < 30) it.countdown_end_ms = sim_now - $urandom_range(5000);
        else it.countdown_end_ms = sim_now + $urandom_range(30000);
        return it;
    endfunction

    // tick sender
    always @(negedge i_clk) begin : drv
        if (i_rst_n && n_ticks == n_offered) begin
            if (pending_ticks.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
                tick_tdata  <= pending_ticks.pop_front();
                tick_tvalid <= 1'b1;
                n_offered++;
            end else begin
                tick_tvalid <= 1'b0;
            end
        end
    end

    // status receiver, with one long hold-off once traffic is flowing
    always @(negedge i_clk) begin : rcv
        if (hold_left != 0) begin
            hold_left--;
            stat_tready <= 1'b0;
        end else if (!hold_done && n_checked >= HoldAfter) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
            stat_tready <= 1'b0;
        end else begin
            stat_tready <= calm || ($urandom_range(99) >= IdlePct);
        end
    end

    // register writes, tick transfers and status transfers
    always @(posedge i_clk) begin : mon
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            pm_mode        = PMODE_AUTO;
            pm_start       = START_LEVEL_RST;
            pm_stop        = STOP_LEVEL_RST;
            pm_bypass      = 1'b0;
            pm_stale       = STALE_MS_RST;
            pm_min_off     = MIN_OFF_MS_RST;
            ps_running     = 1'b0;
            ps_off_valid   = 1'b0;
            ps_off_since   = '0;
            ps_cd_active   = 1'b0;
            ps_cd_deadline = '0;
            ps_fault       = FLT_NONE;
            ps_mode_shown  = RM_AUTO_STBY;
            ps_cool_sec    = '0;
            ps_warn        = 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_PUMP_MODE:   pm_mode    = cfg_wdata[1:0];
                    CFG_START_LEVEL: pm_start   = cfg_wdata[6:0];
                    CFG_STOP_LEVEL:  pm_stop    = cfg_wdata[6:0];
                    CFG_BYPASS:      pm_bypass  = cfg_wdata[0];
                    CFG_STALE_MS:    pm_stale   = cfg_wdata[19:0];
                    CFG_MIN_OFF_MS:  pm_min_off = cfg_wdata[21:0];
                    default: ;
                endcase
            end

            if (tick_tvalid && tick_tready) begin
                pump_tick(t_in_item'(tick_tdata));
                want                   = '0;
                want.pump_on           = ps_running;
                want.run_mode          = ps_mode_shown;
                want.fault_code        = ps_fault;
                want.cooldown_sec      = ps_cool_sec;
                want.runtime_warning   = ps_warn;
                want.countdown_running = ps_cd_active;
                due_status.push_back(want);
                n_ticks++;
            end

            if (stat_tvalid && stat_tready) begin
                got = t_out_item'(stat_tdata);
                n_checked++;
                if (due_status.size() == 0) begin
                    $error("status transfer with no tick outstanding: %h", stat_tdata);
                    n_errors++;
                end else begin
                    want = due_status.pop_front();
                    if (want.pump_on) n_pump_on++;
                    if (got.pump_on !== want.pump_on) begin
                        $error("pump_on: expected %0d, got %0d", want.pump_on, got.pump_on);
                        n_errors++;
                    end
                    if (got.run_mode !== want.run_mode) begin
                        $error("run_mode: expected %0d, got %0d", want.run_mode, got.run_mode);
                        n_errors++;
                    end
                    if (got.fault_code !== want.fault_code) begin
                        $error("fault_code: expected %0d, got %0d",
                               want.fault_code, got.fault_code);
                        n_errors++;
                    end
                    if (got.cooldown_sec !== want.cooldown_sec) begin
                        $error("cooldown_sec: expected %0d, got %0d",
                               want.cooldown_sec, got.cooldown_sec);
                        n_errors++;
                    end
                    if (got.runtime_warning !== want.runtime_warning) begin
                        $error("runtime_warning: expected %0d, got %0d",
                               want.runtime_warning, got.runtime_warning);
                        n_errors++;
                    end
                    if (got.countdown_running !== want.countdown_running) begin
                        $error("countdown_running: expected %0d, got %0d",
                               want.countdown_running, got.countdown_running);
                        n_errors++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin : watchdog
        n_cycles++;
        if (n_cycles >= CycleLimit) begin
            $error("run limit of %0d cycles reached, %0d status transfers outstanding",
                   CycleLimit, due_status.size());
            $display("** pump_level_controller: FAILED **");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CfgAddrW-1:0] addr, input int val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val[CfgDataW-1:0];
    endtask

    // wait until every tick is taken and every status has come back
    task automatic settle();
        @(negedge i_clk);
        while (pending_ticks.size() != 0 || n_ticks != n_offered || due_status.size() != 0)
            @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    // one register setting followed by a batch of random ticks
    task automatic run_phase(input logic [1:0] mode, input int start_lv, input int stop_lv,
                             input int bypass, input int stale, input int min_off);
        cfg_write(CFG_PUMP_MODE, int'(mode));
        cfg_write(CFG_START_LEVEL, start_lv);
        cfg_write(CFG_STOP_LEVEL, stop_lv);
        cfg_write(CFG_BYPASS, bypass);
        cfg_write(CFG_STALE_MS, stale);
        cfg_write(CFG_MIN_OFF_MS, min_off);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        repeat (PhaseTicks) pending_ticks.push_back(field_tick());
        settle();
        n_settings++;
    endtask

    initial begin : stim
        t_in_item d;
        repeat (RstCycles) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks under the reset register values (auto, 30 / 90)
        d = '0;
        pending_ticks.push_back(d);                 // all zero, never-stamped sample
        d = healthy(32'd1000, -1);
        d.estop_latched = 1'b1;
        pending_ticks.push_back(d);                 // no sample: decision skipped
        pending_ticks.push_back(healthy(32'd2000, 10));    // auto start
        pending_ticks.push_back(healthy(32'd3000, 50));
        d = healthy(32'd4000, 50);
        d.sensor_stable = 1'b0;
        pending_ticks.push_back(d);                 // comm loss stops the pump
        pending_ticks.push_back(healthy(32'd5000, 10));    // cooling, no restart
        pending_ticks.push_back(healthy(32'd40000, 10));
        d = healthy(32'd41000, 95);
        d.sleeping = 1'b1;
        pending_ticks.push_back(d);                 // sleep still stops at high level
        d = healthy(32'd80000, 10);
        d.sleeping = 1'b1;
        pending_ticks.push_back(d);                 // sleep never starts
        pending_ticks.push_back(healthy(32'd81000, 10));
        d = healthy(32'd82000, 50);
        d.level_sensor_fault = 1'b1;
        pending_ticks.push_back(d);                 // faulty sensor shows as stale
        pending_ticks.push_back(healthy(32'd120000, 10));
        d = healthy(32'd121000, 50);
        d.safety_stop = SAFE_DRY_RUN;
        pending_ticks.push_back(d);
        d = healthy(32'd160000, 10);
        d.safety_stop = SAFE_OVERFLOW;
        pending_ticks.push_back(d);
        d = healthy(32'd161000, 10);
        d.safety_stop = SAFE_SPARE;
        pending_ticks.push_back(d);                 // unused safety code, no stop
        d = healthy(32'd162000, 20);
        d.estop_latched = 1'b1;
        d.near_runtime_limit = 1'b1;
        pending_ticks.push_back(d);
        d = healthy(32'd200000, 10);
        d.level_stamp_ms = 32'd200000 - 32'd10001;
        pending_ticks.push_back(d);                 // one ms past the stale limit
        d = healthy(32'd200500, 10);
        d.level_stamp_ms = 32'd200500 - 32'd10000;
        pending_ticks.push_back(d);                 // exactly at the stale limit
        d = healthy(32'd201000, 50);
        d.countdown_start  = 1'b1;
        d.countdown_end_ms = 32'd300000;
        pending_ticks.push_back(d);                 // countdown start ignored in auto
        pending_ticks.push_back(healthy(32'hFFFF_FC18, 95));
        d = healthy(32'd500, 10);
        d.level_stamp_ms = 32'hFFFF_FF00;
        pending_ticks.push_back(d);                 // time wrap on age and cooldown
        d = '1;
        d.pad = '0;
        pending_ticks.push_back(d);                 // all ones, no sample
        d.level_pct = 8'sd100;
        pending_ticks.push_back(d);                 // all ones with a sample
        settle();

        // random phases, extremes among the settings
        sim_now   = $urandom;
        sim_level = 50;
        sim_mreq  = 1'b1;
        run_phase(PMODE_AUTO, 30, 90, 0, 10000, 30000);
        run_phase(PMODE_MANUAL, 20, 80, 0, 5000, 10000);
        run_phase(PMODE_COUNTDOWN, 40, 95, 0, 20000, 5000);
        run_phase(PMODE_AUTO, 0, 100, 0, 0, 0);
        run_phase(PMODE_MANUAL, 100, 0, 1, 600000, 3600000);
        run_phase(PMODE_COUNTDOWN, 50, 60, 1, 1, 1);
        run_phase(PMODE_SPARE, 100, 100, 0, 600000, 0);
        run_phase(PMODE_AUTO, 45, 70, 0, 15000, 20000);
        run_phase(PMODE_COUNTDOWN, 10, 100, 0, 8000, 0);
        run_phase(PMODE_MANUAL, 0, 100, 0, 12000, 2500);

        $display("ran %0d ticks under %0d register settings; %0d status transfers checked,",
                 n_ticks, n_settings, n_checked);
        $display("pump driven in %0d of them, one long output hold-off taken", n_pump_on);
        if (n_errors == 0) begin
            $display("** pump_level_controller: PASSED **");
        end else begin
            $display("** pump_level_controller: FAILED **");
        end
        $finish;
    end

endmodule
